@@ sv/tht_pkg.sv @@
// Shared types and constants for the touch hit test table.
package tht_pkg;

   // Table geometry
   localparam int MAX_OBJECTS = 64;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TAG_W       = 16;
   localparam int BOX_W       = 64;
   localparam int ENTRY_W     = TAG_W + BOX_W;

   // Linear map of the raw touch sample
   localparam logic signed [12:0] X_IN_LO = 13'sd150;
   localparam logic signed [12:0] Y_IN_LO = 13'sd130;
   localparam logic [8:0]         X_SPAN  = 9'd310;    // 320 - 10
   localparam logic [8:0]         Y_SPAN  = 9'd230;    // 240 - 10
   localparam logic [15:0]        OUT_LO  = 16'd10;

   // Constant divide by reciprocal multiply: ceil(2**RECIP_SH / den) is exact
   // for every product magnitude below 2**PROD_W on both axes
   localparam int PROD_W   = 21;
   localparam int RECIP_W  = 22;
   localparam int RECIP_SH = 33;
   localparam int MUL_W    = PROD_W + RECIP_W;
   localparam int QUO_W    = 9;
   localparam logic [RECIP_W-1:0] X_RECIP = 22'd2353407;   // den 3800 - 150
   localparam logic [RECIP_W-1:0] Y_RECIP = 22'd2219622;   // den 4000 - 130

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TOUCH = 1'b1;

   // Register indexes
   localparam logic CSR_ACTIVE_SCREEN = 1'b0;
   localparam logic CSR_NUM_OBJECTS   = 1'b1;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [1:0] {
      MAP_NOP,
      MAP_MUL,
      MAP_ABS,
      MAP_DIV
   } map_op_type;

   typedef struct packed {
      map_op_type op;
      logic       axis;
   } map_ctl_type;

   typedef struct packed {
      logic [15:0] point;
   } map_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ABS,
      ST_DIV,
      ST_STORE,
      ST_SCAN,
      ST_OUT
   } state_type;

endpackage

@@ sv/tht_map_unit.sv @@
// Shared multiplier for the touch coordinate map: span product and reciprocal divide.
module tht_map_unit (
   input  logic                  clock,
   input  tht_pkg::map_ctl_type  ctl,
   input  logic [11:0]           raw,
   output tht_pkg::map_stat_type stat
);
   import tht_pkg::*;

   logic [11:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   logic signed [12:0] lo;
   logic [8:0]         span;
   logic [RECIP_W-1:0] recip;
   logic signed [12:0] diff;
   logic signed [12:0] diff_neg;
   logic [PROD_W-1:0]  mul_a;
   logic [RECIP_W-1:0] mul_b;
   logic [MUL_W-1:0]   mul_p;
   logic [15:0]        quo_ext;
   logic [15:0]        quo_sgn;

   always_comb begin
      lo       = (ctl.axis == AXIS_Y) ? Y_IN_LO : X_IN_LO;
      span     = (ctl.axis == AXIS_Y) ? Y_SPAN  : X_SPAN;
      recip    = (ctl.axis == AXIS_Y) ? Y_RECIP : X_RECIP;
      diff     = $signed({1'b0, raw}) - lo;
      diff_neg = -diff;

      // one multiplier: |diff| * span, then product * reciprocal
      mul_a = prod_ff;
      mul_b = recip;
      if (ctl.op == MAP_MUL) begin
         mul_a = PROD_W'(mag_ff);
         mul_b = RECIP_W'(span);
      end
      mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      case (ctl.op)
         MAP_ABS: begin
            neg_in = diff[12];
            mag_in = diff[12] ? diff_neg[11:0] : diff[11:0];
         end
         MAP_MUL: begin
            prod_in = mul_p[PROD_W-1:0];
         end
         MAP_DIV: begin
            quo_in = mul_p[RECIP_SH +: QUO_W];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   // truncation toward zero: divide the magnitude, then restore the sign
   always_comb begin
      quo_ext    = 16'(quo_ff);
      quo_sgn    = neg_ff ? (16'd0 - quo_ext) : quo_ext;
      stat.point = quo_sgn + OUT_LO;
   end

endmodule

@@ sv/touch_hit_test_table_core.sv @@
// Touch hit test table: object table, coordinate map and first-hit scan.
//
// A write request loads one table entry and returns an all-zero response
// through ST_OUT and the output register. A touch request without a touch
// does the same. A touch request maps x and then y through one shared
// multiplier, first the span product and then a reciprocal multiply for the
// constant divide (states ST_ABS, ST_MUL, ST_DIV, ST_STORE per axis), then
// reads the table one entry per cycle through its single read port, stopping
// at the first hit. The block takes one request at a time; req_stall stays
// high from acceptance until the response is loaded into the output register,
// and a new request may be taken while that response waits. Table entries
// have no reset value and must be written before a scan reaches them.
module touch_hit_test_table_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   // requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [5:0]  req_entry_index,
   input  logic [7:0]  req_entry_screen,
   input  logic [7:0]  req_entry_id,
   input  logic signed [15:0] req_box_left,
   input  logic signed [15:0] req_box_top,
   input  logic signed [15:0] req_box_right,
   input  logic signed [15:0] req_box_bottom,
   input  logic        req_touched,
   input  logic [11:0] req_raw_x,
   input  logic [11:0] req_raw_y,
   // responses
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [7:0]  rsp_hit_id,
   output logic [15:0] rsp_point_x,
   output logic [15:0] rsp_point_y
);
   import tht_pkg::*;

   state_type    state_ff, state_in;
   map_ctl_type  map_ctl;
   map_stat_type map_stat;

   logic [7:0]       active_screen_ff;
   logic [6:0]       num_objects_ff;

   logic             axis_ff, axis_in;
   logic [11:0]      raw_x_ff, raw_y_ff;
   logic             hit_ff, hit_in;
   logic [7:0]       hit_id_ff, hit_id_in;
   logic [15:0]      px_ff, px_in;
   logic [15:0]      py_ff, py_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             pend_ff, pend_in;

   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [7:0]       rsp_hit_id_ff;
   logic [15:0]      rsp_point_x_ff, rsp_point_y_ff;

   logic [ENTRY_W-1:0] tbl_mem [MAX_OBJECTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic             req_acc;
   logic             csr_acc;
   logic             mem_we;
   logic             rsp_load;
   logic             match;
   logic [CNT_W-1:0] n_clamp;
   logic signed [16:0] pt_x, pt_y;
   logic signed [16:0] e_left, e_top, e_right, e_bottom;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign req_acc   = req_valid && !req_stall;
   assign mem_we    = req_acc && (req_func == FUNC_WRITE);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_hit_id  = rsp_hit_id_ff;
   assign rsp_point_x = rsp_point_x_ff;
   assign rsp_point_y = rsp_point_y_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_screen_ff <= '0;
         num_objects_ff   <= '0;
      end else if (csr_acc) begin
         case (csr_index)
            CSR_ACTIVE_SCREEN: active_screen_ff <= csr_data;
            CSR_NUM_OBJECTS:   num_objects_ff   <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // object table: entry_index always lies inside the 64-entry table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[req_entry_index] <= {req_entry_screen, req_entry_id,
                                      req_box_bottom, req_box_right,
                                      req_box_top, req_box_left};
      end
      rd_data_ff <= tbl_mem[scan_addr_ff[IDX_W-1:0]];
   end

   tht_map_unit u_map (
      .clock (clock),
      .ctl   (map_ctl),
      .raw   (axis_ff ? raw_y_ff : raw_x_ff),
      .stat  (map_stat)
   );

   // point is unsigned, box edges sign-extended
   always_comb begin
      pt_x     = $signed({1'b0, px_ff});
      pt_y     = $signed({1'b0, py_ff});
      e_left   = $signed({rd_data_ff[15], rd_data_ff[15:0]});
      e_top    = $signed({rd_data_ff[31], rd_data_ff[31:16]});
      e_right  = $signed({rd_data_ff[47], rd_data_ff[47:32]});
      e_bottom = $signed({rd_data_ff[63], rd_data_ff[63:48]});
      match    = pend_ff && (rd_data_ff[79:72] == active_screen_ff) &&
                 (pt_x >= e_left) && (pt_y >= e_top) &&
                 (pt_x <= e_right) && (pt_y <= e_bottom);
      n_clamp  = (CNT_W'(num_objects_ff) > CNT_W'(MAX_OBJECTS)) ?
                 CNT_W'(MAX_OBJECTS) : CNT_W'(num_objects_ff);
   end

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_func == FUNC_TOUCH && req_touched) begin
                  state_in = ST_ABS;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_ABS:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_STORE;
         ST_STORE: state_in = (axis_ff == AXIS_X) ? ST_ABS : ST_SCAN;
         ST_SCAN: begin
            if (match || scan_addr_ff == scan_cnt_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      map_ctl.axis = axis_ff;
      case (state_ff)
         ST_MUL:  map_ctl.op = MAP_MUL;
         ST_ABS:  map_ctl.op = MAP_ABS;
         ST_DIV:  map_ctl.op = MAP_DIV;
         default: map_ctl.op = MAP_NOP;
      endcase
   end

   // working registers
   always_comb begin
      axis_in      = axis_ff;
      hit_in       = hit_ff;
      hit_id_in    = hit_id_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      scan_addr_in = scan_addr_ff;
      scan_cnt_in  = scan_cnt_ff;
      pend_in      = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               axis_in   = AXIS_X;
               hit_in    = 1'b0;
               hit_id_in = '0;
               px_in     = '0;
               py_in     = '0;
            end
         end
         ST_STORE: begin
            if (axis_ff == AXIS_X) begin
               px_in   = map_stat.point;
               axis_in = AXIS_Y;
            end else begin
               py_in = map_stat.point;
            end
            scan_addr_in = '0;
            scan_cnt_in  = n_clamp;
            pend_in      = 1'b0;
         end
         ST_SCAN: begin
            // compare the entry read last cycle while the next read goes out
            if (match) begin
               hit_in    = 1'b1;
               hit_id_in = rd_data_ff[71:64];
               pend_in   = 1'b0;
            end else if (scan_addr_ff != scan_cnt_ff) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         raw_x_ff <= req_raw_x;
         raw_y_ff <= req_raw_y;
      end
      axis_in_reg: begin
         axis_ff      <= axis_in;
         hit_ff       <= hit_in;
         hit_id_ff    <= hit_id_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         scan_addr_ff <= scan_addr_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
      if (rsp_load) begin
         rsp_hit_ff     <= hit_ff;
         rsp_hit_id_ff  <= hit_id_ff;
         rsp_point_x_ff <= px_ff;
         rsp_point_y_ff <= py_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ sv/tht_checker.sv @@
// Port-level checks for the touch hit test table, bound to the top level.
module tht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [7:0]  rsp_hit_id,
   input logic [15:0] rsp_point_x,
   input logic [15:0] rsp_point_y
);

   // a taken request leaves the block busy after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while block not busy afterwards");

   // rsp_valid only rises out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a request in flight");

   // no id without a hit
   a_id_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_id == 8'd0)
      else $error("nonzero hit id on a miss");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
         $stable(rsp_hit_id) && $stable(rsp_point_x) && $stable(rsp_point_y))
      else $error("stalled response changed");

endmodule

bind touch_hit_test_table_core tht_checker u_tht_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_hit     (rsp_hit),
   .rsp_hit_id  (rsp_hit_id),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y)
);

@@ tb/touch_hit_test_table_core_tb.sv @@
// Self-checking testbench for the touch hit test table: writes, touch mapping, first hit.
`timescale 1ns / 1ps

module touch_hit_test_table_core_tb;
   import tht_pkg::*;

   // Touch mapping constants
   localparam int X_RAW_LO  = 150;
   localparam int X_RAW_HI  = 3800;
   localparam int Y_RAW_LO  = 130;
   localparam int Y_RAW_HI  = 4000;
   localparam int PT_LO     = 10;
   localparam int PT_X_HI   = 320;
   localparam int PT_Y_HI   = 240;
   localparam int IDLE_LIMIT = 5000;

   typedef struct {
      logic               func;
      logic [5:0]         index;
      logic [7:0]         screen;
      logic [7:0]         id;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
      logic               touched;
      logic [11:0]        raw_x;
      logic [11:0]        raw_y;
   } touch_req_type;

   typedef struct {
      logic        hit;
      logic [7:0]  hit_id;
      logic [15:0] point_x;
      logic [15:0] point_y;
   } touch_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_ACTIVE_SCREEN;
   logic [7:0]  csr_data = 8'd0;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_WRITE;
   logic [5:0]  req_entry_index = 6'd0;
   logic [7:0]  req_entry_screen = 8'd0;
   logic [7:0]  req_entry_id = 8'd0;
   logic signed [15:0] req_box_left = 16'sd0;
   logic signed [15:0] req_box_top = 16'sd0;
   logic signed [15:0] req_box_right = 16'sd0;
   logic signed [15:0] req_box_bottom = 16'sd0;
   logic        req_touched = 1'b0;
   logic [11:0] req_raw_x = 12'd0;
   logic [11:0] req_raw_y = 12'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [7:0]  rsp_hit_id;
   logic [15:0] rsp_point_x;
   logic [15:0] rsp_point_y;

   touch_hit_test_table_core u_top (.*);

   always #1 clock = ~clock;

   // Shadow object table and registers
   logic [7:0] obj_screen [MAX_OBJECTS];
   logic [7:0] obj_id [MAX_OBJECTS];
   int         obj_left [MAX_OBJECTS];
   int         obj_top [MAX_OBJECTS];
   int         obj_right [MAX_OBJECTS];
   int         obj_bottom [MAX_OBJECTS];
   logic [7:0] cfg_screen = 8'd0;
   logic [6:0] cfg_count = 7'd0;

   touch_req_type pending_reqs[$];
   touch_rsp_type expected_rsps[$];
   int         err_count = 0;
   int         idle_cycles = 0;

   task automatic flag_mismatch(input string msg);
      err_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic logic [15:0] map_axis(logic [11:0] raw, int in_lo, int in_hi, int out_hi);
      int num;
      num = (int'(raw) - in_lo) * (out_hi - PT_LO);
      // SV integer division truncates toward zero
      return 16'((num / (in_hi - in_lo)) + PT_LO);
   endfunction

   // Applies one request to the shadow table and returns its response
   function automatic touch_rsp_type apply_request(touch_req_type r);
      touch_rsp_type rsp;
      int n;
      int x;
      int y;
      rsp = '{hit: 1'b0, hit_id: 8'd0, point_x: 16'd0, point_y: 16'd0};
      if (r.func == FUNC_WRITE) begin
         obj_screen[r.index] = r.screen;
         obj_id[r.index]     = r.id;
         obj_left[r.index]   = r.left;
         obj_top[r.index]    = r.top;
         obj_right[r.index]  = r.right;
         obj_bottom[r.index] = r.bottom;
         return rsp;
      end
      if (!r.touched)
         return rsp;
      rsp.point_x = map_axis(r.raw_x, X_RAW_LO, X_RAW_HI, PT_X_HI);
      rsp.point_y = map_axis(r.raw_y, Y_RAW_LO, Y_RAW_HI, PT_Y_HI);
      x = int'(rsp.point_x);
      y = int'(rsp.point_y);
      n = (cfg_count > MAX_OBJECTS) ? MAX_OBJECTS : int'(cfg_count);
      for (int i = 0; i < n; i++) begin
         if (!rsp.hit && obj_screen[i] == cfg_screen &&
             x >= obj_left[i] && y >= obj_top[i] &&
             x <= obj_right[i] && y <= obj_bottom[i]) begin
            rsp.hit    = 1'b1;
            rsp.hit_id = obj_id[i];
         end
      end
      return rsp;
   endfunction

   // Request driver: bursts of random length with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      touch_req_type nxt;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            req_valid        <= 1'b1;
            req_func         <= nxt.func;
            req_entry_index  <= nxt.index;
            req_entry_screen <= nxt.screen;
            req_entry_id     <= nxt.id;
            req_box_left     <= nxt.left;
            req_box_top      <= nxt.top;
            req_box_right    <= nxt.right;
            req_box_bottom   <= nxt.bottom;
            req_touched      <= nxt.touched;
            req_raw_x        <= nxt.raw_x;
            req_raw_y        <= nxt.raw_y;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: a new random mode is picked each time the 6-bit tick wraps
   logic [5:0] stall_tick = 6'd0;
   logic [1:0] stall_mode = 2'd0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_tick <= 6'd0;
         stall_mode <= 2'd0;
      end else begin
         stall_tick <= stall_tick + 6'd1;
         if (stall_tick == 6'd63)
            stall_mode <= 2'($urandom_range(0, 3));
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= 1'($urandom_range(0, 1));
            2'd2: rsp_stall <= (stall_tick[1:0] != 2'd0);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // Monitor: register writes, request prediction, response check
   always @(posedge clock) begin
      touch_req_type cur;
      touch_rsp_type want;
      bit busy;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         busy = 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_SCREEN)
               cfg_screen = csr_data;
            else
               cfg_count = csr_data[6:0];
            busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (expected_rsps.size() == 0) begin
               flag_mismatch($sformatf("unexpected response hit=%0d id=%0d x=%0d y=%0d",
                                       rsp_hit, rsp_hit_id, rsp_point_x, rsp_point_y));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_hit !== want.hit)
                  flag_mismatch($sformatf("hit got %0d want %0d", rsp_hit, want.hit));
               if (rsp_hit_id !== want.hit_id)
                  flag_mismatch($sformatf("hit_id got %0d want %0d", rsp_hit_id, want.hit_id));
               if (rsp_point_x !== want.point_x)
                  flag_mismatch($sformatf("point_x got %0d want %0d", rsp_point_x, want.point_x));
               if (rsp_point_y !== want.point_y)
                  flag_mismatch($sformatf("point_y got %0d want %0d", rsp_point_y, want.point_y));
            end
         end
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            cur = '{func: req_func, index: req_entry_index, screen: req_entry_screen,
                    id: req_entry_id, left: req_box_left, top: req_box_top,
                    right: req_box_right, bottom: req_box_bottom, touched: req_touched,
                    raw_x: req_raw_x, raw_y: req_raw_y};
            expected_rsps.push_back(apply_request(cur));
         end
         idle_cycles <= busy ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("touch_hit_test_table_core_tb: errors");
      $finish;
   end

   function automatic touch_req_type random_req();
      touch_req_type r;
      r.func    = 1'($urandom);
      r.index   = 6'($urandom);
      r.screen  = 8'($urandom);
      r.id      = 8'($urandom);
      r.left    = 16'($urandom);
      r.top     = 16'($urandom);
      r.right   = 16'($urandom);
      r.bottom  = 16'($urandom);
      r.touched = 1'($urandom);
      r.raw_x   = 12'($urandom);
      r.raw_y   = 12'($urandom);
      return r;
   endfunction

   function automatic touch_req_type write_req(int idx, int scr, int id, int l, int t, int rt,
                                               int b);
      touch_req_type r;
      r = random_req();
      r.func   = FUNC_WRITE;
      r.index  = 6'(idx);
      r.screen = 8'(scr);
      r.id     = 8'(id);
      r.left   = 16'(l);
      r.top    = 16'(t);
      r.right  = 16'(rt);
      r.bottom = 16'(b);
      return r;
   endfunction

   function automatic touch_req_type touch_req(bit touched, int rx, int ry);
      touch_req_type r;
      r = random_req();
      r.func    = FUNC_TOUCH;
      r.touched = touched;
      r.raw_x   = 12'(rx);
      r.raw_y   = 12'(ry);
      return r;
   endfunction

   // Object write with a box near the mapped screen area, sometimes inverted or wild
   function automatic touch_req_type random_write(int idx, logic [7:0] scr);
      touch_req_type r;
      int l;
      int t;
      r = random_req();
      r.func   = FUNC_WRITE;
      r.index  = 6'(idx);
      r.screen = ($urandom_range(0, 3) == 0) ? 8'($urandom) : scr;
      if ($urandom_range(0, 7) != 0) begin
         l = $urandom_range(0, 330);
         t = $urandom_range(0, 250);
         r.left   = 16'(l);
         r.top    = 16'(t);
         r.right  = ($urandom_range(0, 7) == 0) ? 16'(l - $urandom_range(1, 50))
                                                : 16'(l + $urandom_range(0, 150));
         r.bottom = ($urandom_range(0, 7) == 0) ? 16'(t - $urandom_range(1, 50))
                                                : 16'(t + $urandom_range(0, 120));
      end
      return r;
   endfunction

   task automatic write_csr(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] scr, input logic [7:0] cnt);
      write_csr(CSR_ACTIVE_SCREEN, scr);
      write_csr(CSR_NUM_OBJECTS, cnt);
      @(negedge clock);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   task automatic random_phase(input int n, input logic [7:0] scr, input logic [7:0] cnt);
      touch_req_type r;
      set_config(scr, cnt);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            r = random_write($urandom_range(0, MAX_OBJECTS - 1), scr);
         end else begin
            r = random_req();
            r.func    = FUNC_TOUCH;
            r.touched = ($urandom_range(0, 9) != 0);
         end
         pending_reqs.push_back(r);
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty scan: touches see no objects; then load the first entries
      set_config(8'd0, 8'd0);
      pending_reqs.push_back(touch_req(1'b0, 2000, 2000));
      pending_reqs.push_back(touch_req(1'b1, 0, 0));
      pending_reqs.push_back(touch_req(1'b1, 4095, 4095));
      pending_reqs.push_back(write_req(0, 5, 8'h11, 100, 50, 200, 150));
      pending_reqs.push_back(write_req(1, 9, 8'h22, -32768, -32768, 32767, 32767));
      pending_reqs.push_back(write_req(2, 5, 0, 10, 10, 10, 10));
      pending_reqs.push_back(write_req(3, 5, 8'h33, 300, 50, 200, 150));
      pending_reqs.push_back(write_req(4, 5, 8'hFF, -32768, -32768, 32767, 32767));
      for (int i = 5; i < 8; i++)
         pending_reqs.push_back(random_write(i, 8'd5));
      pending_reqs.push_back(write_req(63, 255, 8'hAA, 0, 0, 400, 300));
      drain();

      // Directed touches on screen 5 over the first eight entries
      set_config(8'd5, 8'd8);
      pending_reqs.push_back(touch_req(1'b1, 150, 130));    // id zero object at (10,10)
      pending_reqs.push_back(touch_req(1'b1, 1210, 804));   // top-left edge of entry 0
      pending_reqs.push_back(touch_req(1'b1, 2388, 2486));  // bottom-right edge of entry 0
      pending_reqs.push_back(touch_req(1'b1, 3100, 2486));  // between the swapped edges of entry 3, outside entry 0
      pending_reqs.push_back(touch_req(1'b1, 3800, 4000));
      pending_reqs.push_back(touch_req(1'b1, 0, 0));        // x wraps to a large value
      pending_reqs.push_back(touch_req(1'b1, 4095, 4095));
      pending_reqs.push_back(touch_req(1'b0, 1500, 1500));
      drain();

      // Fill the rest of the table so any count is safe to scan
      set_config(8'd5, 8'd8);
      for (int i = 8; i < 63; i++) begin
         pending_reqs.push_back(random_write(i, 8'd5));
         if (i % 6 == 0)
            pending_reqs.push_back(touch_req(1'b1, $urandom_range(0, 4095),
                                             $urandom_range(0, 4095)));
      end
      drain();

      random_phase(160, 8'd0, 8'd64);
      random_phase(160, 8'd255, 8'd127);
      random_phase(160, 8'd5, 8'd1);
      random_phase(160, 8'($urandom), 8'hC1);   // bit 7 is dropped: scans 65 -> 64
      random_phase(160, 8'd9, 8'($urandom_range(2, 63)));
      random_phase(160, 8'd5, 8'd64);

      repeat (200) @(posedge clock);
      if (expected_rsps.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      if (err_count == 0)
         $display("touch_hit_test_table_core_tb: clean");
      else
         $display("touch_hit_test_table_core_tb: errors");
      $finish;
   end

endmodule

@@ sim.f @@
sv/tht_pkg.sv
sv/tht_map_unit.sv
sv/touch_hit_test_table_core.sv
sv/tht_checker.sv
tb/touch_hit_test_table_core_tb.sv
